// ===== hdl/slip_frame_receiver_unit_macros.svh =====
// Assertion helpers used by the receiver back end (sfr_back).
`ifndef SLIP_FRAME_RECEIVER_UNIT_MACROS_SVH
`define SLIP_FRAME_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SFR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("slip receiver check failed");

// Next-cycle implication, checked out of reset.
`define SFR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("slip receiver check failed");

`endif

// ===== hdl/sfr_pkg.sv =====
package sfr_pkg;

    localparam int FRAME_BYTES_DEF = 64;
    localparam int LEN_W           = 6;
    localparam int Q_DEPTH         = 4;

    localparam logic [7:0] FEND  = 8'hC0;
    localparam logic [7:0] FESC  = 8'hDB;
    localparam logic [7:0] TFEND = 8'hDC;
    localparam logic [7:0] TFESC = 8'hDD;

    typedef enum logic [0:0] {
        OP_WRITE,
        OP_CLOSE
    } op_t;

    // WRITE: data goes to store address arg. CLOSE: drain arg bytes.
    typedef struct packed {
        op_t              op;
        logic [LEN_W-1:0] arg;
        logic [7:0]       data;
    } q_entry_t;

    typedef enum logic [0:0] {
        BK_IDLE,
        BK_DRAIN
    } back_state_t;

endpackage

// ===== hdl/slip_frame_receiver_unit.sv =====
// SLIP frame receiver: one raw byte per transaction, decoded frame out byte by byte.
// Input: one byte per cycle while the 4-entry command queue has room.
// Closing END: CLOSE queued, then popped, then store read into the output register.
// Drain: one payload byte per cycle while m_ready is high, set by the store read port.
// Reset (aresetn low, synchronous) clears framing state, queue and output valid;
// the payload store is not cleared and needs no clearing pass.
module slip_frame_receiver_unit #(
    parameter int FRAME_BYTES = sfr_pkg::FRAME_BYTES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_rx_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_out_byte,
    output logic                      m_last_of_frame,
    output logic [sfr_pkg::LEN_W-1:0] m_frame_length
);
    import sfr_pkg::*;

    q_entry_t push_entry;
    q_entry_t pop_entry;
    logic     push;
    logic     full;
    logic     pop_valid;
    logic     pop_ready;

    sfr_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_full    (full),
        .q_push    (push),
        .q_entry   (push_entry)
    );

    sfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    sfr_back #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (pop_valid),
        .q_ready         (pop_ready),
        .q_entry         (pop_entry),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_last_of_frame (m_last_of_frame),
        .m_frame_length  (m_frame_length)
    );

endmodule

// ===== hdl/sfr_front.sv =====
module sfr_front #(
    parameter int FRAME_BYTES = sfr_pkg::FRAME_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_byte,
    input  logic              q_full,
    output logic              q_push,
    output sfr_pkg::q_entry_t q_entry
);
    import sfr_pkg::*;

    localparam int CNT_W = $clog2(FRAME_BYTES);
    localparam logic [CNT_W-1:0] RAW_LIMIT = CNT_W'(FRAME_BYTES - 1);

    logic             receiving_reg, receiving_next;
    logic             esc_reg, esc_next;
    logic [CNT_W-1:0] raw_reg, raw_next;
    logic [CNT_W-1:0] dec_reg, dec_next;

    assign s_ready = !q_full;

    always_comb begin
        logic       do_store;
        logic [7:0] store_byte;
        do_store       = 1'b0;
        store_byte     = s_rx_byte;
        receiving_next = receiving_reg;
        esc_next       = esc_reg;
        raw_next       = raw_reg;
        dec_next       = dec_reg;
        q_push         = 1'b0;
        q_entry.op     = OP_WRITE;
        q_entry.arg    = LEN_W'(dec_reg);
        q_entry.data   = s_rx_byte;
        if (s_valid && s_ready) begin
            if (!receiving_reg) begin
                if (s_rx_byte == FEND) begin
                    receiving_next = 1'b1;
                    esc_next       = 1'b0;
                    raw_next       = '0;
                    dec_next       = '0;
                end
            end else if (raw_reg >= RAW_LIMIT) begin
                // overflow: drop the frame, discard this byte
                receiving_next = 1'b0;
                esc_next       = 1'b0;
                raw_next       = '0;
                dec_next       = '0;
            end else if (s_rx_byte == FEND) begin
                if (raw_reg != '0) begin
                    if (dec_reg != '0) begin
                        q_push     = 1'b1;
                        q_entry.op = OP_CLOSE;
                    end
                    receiving_next = 1'b0;
                    esc_next       = 1'b0;
                    raw_next       = '0;
                    dec_next       = '0;
                end
            end else begin
                raw_next = raw_reg + 1'b1;
                if (esc_reg) begin
                    esc_next = 1'b0;
                    do_store = 1'b1;
                    if (s_rx_byte == TFEND) begin
                        store_byte = FEND;
                    end else if (s_rx_byte == TFESC) begin
                        store_byte = FESC;
                    end
                end else if (s_rx_byte == FESC) begin
                    esc_next = 1'b1;
                end else begin
                    do_store = 1'b1;
                end
                if (do_store) begin
                    q_push       = 1'b1;
                    q_entry.data = store_byte;
                    dec_next     = dec_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            receiving_reg <= 1'b0;
            esc_reg       <= 1'b0;
            raw_reg       <= '0;
            dec_reg       <= '0;
        end else begin
            receiving_reg <= receiving_next;
            esc_reg       <= esc_next;
            raw_reg       <= raw_next;
            dec_reg       <= dec_next;
        end
    end

endmodule

// ===== hdl/sfr_queue.sv =====
module sfr_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  sfr_pkg::q_entry_t push_entry,
    output logic              full,
    output logic              pop_valid,
    input  logic              pop_ready,
    output sfr_pkg::q_entry_t pop_entry
);
    import sfr_pkg::*;

    localparam int QP_W = $clog2(Q_DEPTH);

    q_entry_t        slots_reg [Q_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QP_W:0]   count_reg, count_next;
    logic            do_pop;

    assign full      = (count_reg == (QP_W+1)'(Q_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = slots_reg[rd_ptr_reg];
    assign do_pop    = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/sfr_back.sv =====
`include "slip_frame_receiver_unit_macros.svh"

module sfr_back #(
    parameter int FRAME_BYTES = sfr_pkg::FRAME_BYTES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  sfr_pkg::q_entry_t         q_entry,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_out_byte,
    output logic                      m_last_of_frame,
    output logic [sfr_pkg::LEN_W-1:0] m_frame_length
);
    import sfr_pkg::*;

    localparam int CNT_W = $clog2(FRAME_BYTES);

    logic [7:0]       store_mem [FRAME_BYTES];
    back_state_t      state_reg, state_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       out_byte_reg;
    logic             last_reg;
    logic [CNT_W-1:0] out_len_reg;
    logic             issue;
    logic             issue_last;

    // outputs of the sequencer
    always_comb begin
        q_ready    = (state_reg == BK_IDLE);
        issue      = (state_reg == BK_DRAIN) && (!m_valid_reg || m_ready);
        issue_last = (rd_idx_reg == len_reg - 1'b1);
    end

    // next state
    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        rd_idx_next  = rd_idx_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            BK_IDLE: begin
                if (q_valid && q_entry.op == OP_CLOSE) begin
                    state_next  = BK_DRAIN;
                    len_next    = q_entry.arg[CNT_W-1:0];
                    rd_idx_next = '0;
                end
            end
            BK_DRAIN: begin
                if (issue) begin
                    m_valid_next = 1'b1;
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    if (issue_last) begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // store: write from the queue, registered read straight into the output slot
    always_ff @(posedge aclk) begin
        if (q_valid && q_ready && q_entry.op == OP_WRITE) begin
            store_mem[q_entry.arg[CNT_W-1:0]] <= q_entry.data;
        end
        if (issue) begin
            out_byte_reg <= store_mem[rd_idx_reg];
            last_reg     <= issue_last;
            out_len_reg  <= len_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            len_reg     <= '0;
            rd_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            rd_idx_reg  <= rd_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = out_byte_reg;
    assign m_last_of_frame = last_reg;
    assign m_frame_length  = LEN_W'(out_len_reg);

    `SFR_ASSERT_NOW(a_drain_len_nonzero, aclk, aresetn, state_reg == BK_DRAIN, len_reg != '0)
    `SFR_ASSERT_NOW(a_drain_idx_in_range, aclk, aresetn, state_reg == BK_DRAIN, rd_idx_reg < len_reg)
    `SFR_ASSERT_NEXT(a_last_ends_drain, aclk, aresetn, issue && issue_last, state_reg == BK_IDLE)
    `SFR_ASSERT_NEXT(a_issue_shows_result, aclk, aresetn, issue, m_valid_reg)

endmodule

// ===== bench/slip_frame_checker.sv =====
`timescale 1ns / 100ps

module slip_frame_checker #(
    parameter int FRAME_BYTES = sfr_pkg::FRAME_BYTES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [7:0]                s_rx_byte,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [7:0]                m_out_byte,
    input  logic                      m_last_of_frame,
    input  logic [sfr_pkg::LEN_W-1:0] m_frame_length,
    output int                        fail_count,
    output int                        outstanding,
    output int                        bytes_checked
);
    import sfr_pkg::*;

    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic [LEN_W-1:0] len;
    } decoded_beat_t;

    // Shadow deframer state
    logic       rx_active;
    logic       esc_seen;
    int         raw_len;
    int         dec_len;
    logic [7:0] frame_buf [FRAME_BYTES];

    decoded_beat_t decoded_q[$];

    task automatic clear_frame();
        esc_seen = 1'b0;
        raw_len  = 0;
        dec_len  = 0;
    endtask

    task automatic keep_byte(input logic [7:0] b);
        frame_buf[dec_len] = b;
        dec_len++;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        decoded_beat_t beat;
        int            k;
        if (!rx_active) begin
            if (b == FEND) begin
                rx_active = 1'b1;
                clear_frame();
            end
        end else if (raw_len >= FRAME_BYTES - 1) begin
            // overflow: drop the frame, the byte itself is discarded
            rx_active = 1'b0;
            clear_frame();
        end else if (b == FEND) begin
            if (raw_len != 0) begin
                for (k = 0; k < dec_len; k++) begin
                    beat.data = frame_buf[k];
                    beat.last = (k + 1 == dec_len);
                    beat.len  = dec_len[LEN_W-1:0];
                    decoded_q.push_back(beat);
                end
                rx_active = 1'b0;
                clear_frame();
            end
        end else begin
            raw_len++;
            if (esc_seen) begin
                esc_seen = 1'b0;
                if (b == TFEND)
                    keep_byte(FEND);
                else if (b == TFESC)
                    keep_byte(FESC);
                else
                    keep_byte(b);
            end else if (b == FESC) begin
                esc_seen = 1'b1;
            end else begin
                keep_byte(b);
            end
        end
    endtask

    always @(posedge aclk) begin
        decoded_beat_t want;
        if (!aresetn) begin
            rx_active = 1'b0;
            clear_frame();
            decoded_q.delete();
            fail_count    = 0;
            bytes_checked = 0;
        end else begin
            if (s_valid && s_ready)
                absorb_byte(s_rx_byte);
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    fail_count++;
                    $error("unexpected transaction: out_byte %0h last %0b length %0d",
                           m_out_byte, m_last_of_frame, m_frame_length);
                end else begin
                    want = decoded_q.pop_front();
                    bytes_checked++;
                    if (m_out_byte !== want.data) begin
                        fail_count++;
                        $error("out_byte: expected %0h, actual %0h", want.data, m_out_byte);
                    end
                    if (m_last_of_frame !== want.last) begin
                        fail_count++;
                        $error("last_of_frame: expected %0b, actual %0b",
                               want.last, m_last_of_frame);
                    end
                    if (m_frame_length !== want.len) begin
                        fail_count++;
                        $error("frame_length: expected %0d, actual %0d",
                               want.len, m_frame_length);
                    end
                end
            end
        end
        outstanding <= decoded_q.size();
    end

endmodule

// ===== bench/slip_frame_receiver_unit_tb.sv =====
`timescale 1ns / 100ps

module slip_frame_receiver_unit_tb;
    import sfr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 195;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    logic [7:0]       s_rx_byte = 8'h00;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    logic [7:0]       m_out_byte;
    logic             m_last_of_frame;
    logic [LEN_W-1:0] m_frame_length;

    int   fail_count;
    int   outstanding;
    int   bytes_checked;
    int   cycle_count = 0;
    int   raw_sent    = 0;
    int   noise_sent  = 0;
    int   frames_sent = 0;
    logic gaps_on     = 1'b1;

    slip_frame_receiver_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_last_of_frame (m_last_of_frame),
        .m_frame_length  (m_frame_length)
    );

    slip_frame_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_last_of_frame (m_last_of_frame),
        .m_frame_length  (m_frame_length),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .bytes_checked   (bytes_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Sink: ready in random runs, stalled in bursts while gaps are enabled
    initial begin
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            if (gaps_on && $urandom_range(0, 1)) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
        end
    end

    // Hold valid until the transaction is taken; valid stays up for the next one.
    task automatic put_byte(input logic [7:0] b);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        raw_sent++;
    endtask

    task automatic put_decoded(input logic [7:0] b);
        if (b == FEND) begin
            put_byte(FESC);
            put_byte(TFEND);
        end else if (b == FESC) begin
            put_byte(FESC);
            put_byte(TFESC);
        end else begin
            put_byte(b);
        end
    endtask

    task automatic drain_wait();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Lean toward the four framing codes
    function automatic logic [7:0] pick_payload();
        logic [7:0] specials [4];
        specials = '{FEND, FESC, TFEND, TFESC};
        if ($urandom_range(0, 3) == 0)
            return specials[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        logic [7:0] b;
        int         n;
        int         i;
        int         kind;
        logic       drained;

        drained = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Idle bytes, then open with a repeated END
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(FEND);
        put_byte(FEND);
        // Extremes, both escapes, escaped plain byte, escaped ESC, trailing lone ESC
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(FESC);
        put_byte(TFEND);
        put_byte(FESC);
        put_byte(TFESC);
        put_byte(FESC);
        put_byte(8'h41);
        put_byte(FESC);
        put_byte(FESC);
        put_byte(FESC);
        put_byte(FEND);
        // Frame holding only a lone ESC closes with nothing out
        put_byte(FEND);
        put_byte(FESC);
        put_byte(FEND);
        // Single-byte frame
        put_byte(FEND);
        put_byte(8'h7E);
        put_byte(FEND);
        frames_sent += 3;

        while ((raw_sent - noise_sent < RANDOM_ITEMS) || (frames_sent < 10)) begin
            if (!drained && raw_sent - noise_sent >= 90) begin
                drain_wait();
                drained = 1'b1;
            end
            // Back to back on both sides for the last part
            if (raw_sent - noise_sent >= 170)
                gaps_on = 1'b0;

            if (frames_sent == 5)
                kind = 0;
            else if (frames_sent == 9)
                kind = 1;
            else
                kind = ($urandom_range(0, 5) == 0) ? 2 : 3;

            put_byte(FEND);
            case (kind)
                0: begin
                    // Longest frame that still closes
                    for (i = 0; i < FRAME_BYTES_DEF - 2; i++) begin
                        b = 8'($urandom_range(0, 255));
                        if (b == FEND || b == FESC)
                            b = ~b;
                        put_byte(b);
                    end
                    put_byte(FEND);
                end
                1: begin
                    // Overflow: the END after a full frame is dropped, not reopened
                    for (i = 0; i < FRAME_BYTES_DEF - 1; i++) begin
                        b = 8'($urandom_range(0, 255));
                        if (b == FEND)
                            b = 8'h3C;
                        put_byte(b);
                    end
                    put_byte(FEND);
                    put_byte(8'h5A);
                end
                2: begin
                    // Broken: raw bytes with no proper close
                    n = $urandom_range(1, 6);
                    for (i = 0; i < n; i++)
                        put_byte(pick_payload());
                end
                default: begin
                    if ($urandom_range(0, 4) == 0)
                        put_byte(FEND);
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                                    : $urandom_range(1, 8);
                    for (i = 0; i < n; i++) begin
                        if ($urandom_range(0, 11) == 0) begin
                            b = 8'($urandom_range(0, 255));
                            if (b == FEND)
                                b = 8'h00;
                            put_byte(FESC);
                            put_byte(b);
                        end else begin
                            put_decoded(pick_payload());
                        end
                    end
                    if ($urandom_range(0, 7) == 0)
                        put_byte(FESC);
                    put_byte(FEND);
                    // Idle noise, ignored while no frame is open
                    if ($urandom_range(0, 5) == 0) begin
                        n = $urandom_range(1, 3);
                        for (i = 0; i < n; i++) begin
                            b = 8'($urandom_range(0, 255));
                            if (b == FEND)
                                b = 8'hFF;
                            put_byte(b);
                        end
                        noise_sent += n;
                    end
                end
            endcase
            frames_sent++;
        end

        drain_wait();
        $display("sent %0d raw bytes in %0d frames, compared %0d decoded bytes",
                 raw_sent, frames_sent, bytes_checked);
        $display("included escapes, empty and lone-ESC frames, a 62-byte frame and an overflow");
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sfr_pkg.sv
hdl/sfr_front.sv
hdl/sfr_queue.sv
hdl/sfr_back.sv
hdl/slip_frame_receiver_unit.sv
bench/slip_frame_checker.sv
bench/slip_frame_receiver_unit_tb.sv
